// File: src/utf8_text_width_meter_core_macros.svh
// Assertion macros shared by the width meter RTL.
`ifndef UTF8_TEXT_WIDTH_METER_CORE_MACROS_SVH
`define UTF8_TEXT_WIDTH_METER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define UTWM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utwm assertion failed");
`define UTWM_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("utwm reset assertion failed");
`else
`define UTWM_ASSERT(label, clk, rst, prop)
`define UTWM_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: src/utwm_pkg.sv
// Shared types and constants of the UTF-8 text width meter.
`default_nettype none
package utwm_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int MID_DEPTH_DEFAULT   = 4;
   localparam int OUT_DEPTH_DEFAULT   = 8;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef enum logic {
      OP_TABLE_WRITE = 1'b0,
      OP_TEXT_BYTE   = 1'b1
   } opcode_type;

   // Classified beat handed from the decoder to the accumulator
   typedef struct packed {
      logic        is_text;
      logic        done;
      logic [7:0]  slot;
      logic        missing;
      logic        last;
      logic [7:0]  table_index;
      logic [15:0] advance_value;
   } mid_item_type;

   typedef struct packed {
      logic        char_done;
      logic [7:0]  glyph_index;
      logic        missing_glyph;
      logic [31:0] running_width;
      logic        width_valid;
      logic [31:0] final_width;
   } out_item_type;

endpackage
`default_nettype wire

// File: src/utwm_queue.sv
// Small register queue used between the pipeline parts and at the result side.
`default_nettype none
module utwm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: src/utwm_front.sv
// UTF-8 decoder and glyph slot classifier.
`default_nettype none
module utwm_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  opcode,
   input  wire logic [7:0]            table_index,
   input  wire logic [15:0]           advance_value,
   input  wire logic [7:0]            text_byte,
   input  wire logic                  last,
   output utwm_pkg::mid_item_type     item
);
   localparam logic [20:0] ASCII_LO = 21'h20;
   localparam logic [20:0] ASCII_HI = 21'h7E;
   localparam logic [20:0] CYR_LO   = 21'h410;
   localparam logic [20:0] CYR_HI   = 21'h44F;
   localparam logic [20:0] YO_UP    = 21'h401;
   localparam logic [20:0] YO_LO    = 21'h451;
   localparam logic [7:0]  ASCII_SLOTS = 8'd95;
   localparam logic [7:0]  YO_UP_SLOT  = 8'd159;
   localparam logic [7:0]  YO_LO_SLOT  = 8'd160;
   localparam logic [7:0]  N_SLOT      = 8'd78;

   logic [20:0] pc_ff, pc_in;
   logic [1:0]  rem_ff, rem_in;
   logic [20:0] cp;
   logic        done;
   logic [7:0]  slot;
   logic        missing;
   logic        is_text;

   assign is_text = (opcode == utwm_pkg::OP_TEXT_BYTE);

   always_comb begin
      pc_in  = pc_ff;
      rem_in = rem_ff;
      cp     = '0;
      done   = 1'b0;
      if (rem_ff != 2'd0 && text_byte[7:6] == 2'b10) begin
         // continuation: shift in six bits
         pc_in  = {pc_ff[14:0], text_byte[5:0]};
         rem_in = rem_ff - 2'd1;
         if (rem_ff == 2'd1) begin
            cp    = pc_in;
            done  = 1'b1;
            pc_in = '0;
         end
      end else begin
         // new lead byte; drop any open sequence
         pc_in  = '0;
         rem_in = 2'd0;
         if (text_byte == 8'h00) begin
            done = 1'b0;
         end else if (text_byte[7] == 1'b0) begin
            cp   = {13'd0, text_byte};
            done = 1'b1;
         end else if (text_byte[7:5] == 3'b110) begin
            pc_in  = {16'd0, text_byte[4:0]};
            rem_in = 2'd1;
         end else if (text_byte[7:4] == 4'b1110) begin
            pc_in  = {17'd0, text_byte[3:0]};
            rem_in = 2'd2;
         end else if (text_byte[7:3] == 5'b11110) begin
            pc_in  = {18'd0, text_byte[2:0]};
            rem_in = 2'd3;
         end
      end
      if (last) begin
         pc_in  = '0;
         rem_in = 2'd0;
      end
   end

   always_comb begin
      missing = 1'b0;
      if (cp >= ASCII_LO && cp <= ASCII_HI) begin
         slot = 8'(cp - ASCII_LO);
      end else if (cp >= CYR_LO && cp <= CYR_HI) begin
         slot = ASCII_SLOTS + 8'(cp - CYR_LO);
      end else if (cp == YO_UP) begin
         slot = YO_UP_SLOT;
      end else if (cp == YO_LO) begin
         slot = YO_LO_SLOT;
      end else begin
         slot    = N_SLOT;
         missing = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         rem_ff <= '0;
      end else if (accept && is_text) begin
         pc_ff  <= pc_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      item.is_text       = is_text;
      item.done          = is_text && done;
      item.slot          = slot;
      item.missing       = missing;
      item.last          = is_text && last;
      item.table_index   = table_index;
      item.advance_value = advance_value;
   end

endmodule
`default_nettype wire

// File: src/utwm_back.sv
// Advance table, width accumulator and final scaling pipeline.
`default_nettype none
module utwm_back #(
   parameter int TABLE_DEPTH = utwm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int OUT_DEPTH   = utwm_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [15:0]                  csr_wdata,
   input  wire logic                         mid_empty,
   input  wire utwm_pkg::mid_item_type       mid_item,
   output logic                              mid_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                              out_push,
   output utwm_pkg::out_item_type            out_item
);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic [15:0] table_mem [TABLE_DEPTH];
   logic [15:0] adv_ff;
   logic [15:0] scale_ff;

   logic                   s1_v_ff;
   utwm_pkg::mid_item_type s1_item_ff;

   logic [31:0] acc_ff, acc_in;
   logic [31:0] running;
   logic [32:0] sum;

   logic        s2_v_ff;
   logic [31:0] s2_running_ff;
   logic        s2_done_ff, s2_missing_ff, s2_last_ff;
   logic [7:0]  s2_slot_ff;

   logic        s3_v_ff;
   logic [47:0] s3_prod_ff;
   logic [31:0] s3_running_ff;
   logic        s3_done_ff, s3_missing_ff, s3_last_ff;
   logic [7:0]  s3_slot_ff;

   logic        credit_ok;
   logic        tbl_we;
   logic        tbl_re;

   // hold off when the result queue could not take every beat in flight
   assign credit_ok = (int'(out_count) + int'(s1_v_ff) + int'(s2_v_ff) + int'(s3_v_ff))
                      < OUT_DEPTH;
   assign mid_pop   = !mid_empty && credit_ok;
   assign tbl_we    = mid_pop && !mid_item.is_text && (int'(mid_item.table_index) < TABLE_DEPTH);
   assign tbl_re    = mid_pop && mid_item.done;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[AW'(mid_item.table_index)] <= mid_item.advance_value;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_re) begin
         adv_ff <= table_mem[AW'(mid_item.slot)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= utwm_pkg::SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= mid_pop;
      end
      if (mid_pop) begin
         s1_item_ff <= mid_item;
      end
   end

   // saturating add of the looked-up advance
   always_comb begin
      sum     = {1'b0, acc_ff} + {17'd0, adv_ff};
      running = acc_ff;
      if (s1_item_ff.done) begin
         running = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      acc_in = s1_item_ff.last ? 32'd0 : running;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
         if (s1_v_ff) begin
            acc_ff <= acc_in;
         end
      end
      if (s1_v_ff) begin
         s2_running_ff <= running;
         s2_done_ff    <= s1_item_ff.done;
         s2_missing_ff <= s1_item_ff.missing;
         s2_last_ff    <= s1_item_ff.last;
         s2_slot_ff    <= s1_item_ff.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      if (s2_v_ff) begin
         s3_prod_ff    <= s2_running_ff * {16'd0, scale_ff};
         s3_running_ff <= s2_running_ff;
         s3_done_ff    <= s2_done_ff;
         s3_missing_ff <= s2_missing_ff;
         s3_last_ff    <= s2_last_ff;
         s3_slot_ff    <= s2_slot_ff;
      end
   end

   assign out_push = s3_v_ff;

   always_comb begin
      out_item.char_done     = s3_done_ff;
      out_item.glyph_index   = s3_done_ff ? s3_slot_ff : 8'd0;
      out_item.missing_glyph = s3_done_ff && s3_missing_ff;
      out_item.running_width = s3_running_ff;
      out_item.width_valid   = s3_last_ff;
      out_item.final_width   = 32'd0;
      if (s3_last_ff) begin
         out_item.final_width = (s3_prod_ff[47:40] != 8'd0) ? 32'hFFFF_FFFF
                                                            : s3_prod_ff[39:8];
      end
   end

endmodule
`default_nettype wire

// File: src/utf8_text_width_meter_core.sv
// Top level of the UTF-8 text width meter.
//
//   channel   direction  handshake        payload
//   request   in         push / full      req_opcode .. req_last
//   response  out        pop / empty      rsp_char_done .. rsp_final_width
//   csr       in         csr_we           csr_wdata (width scale, Q8.8)
//
// One beat per cycle is sustained in both directions unless full is set or
// the back end waits for result-queue room; one table read per beat. A taken
// beat passes the decode queue, stages s1, s2, s3 and the result queue.
// Reset clears the decoder, the accumulator and both queues; the advance
// table is not cleared and must be written before use.
// full rises when the four-entry decode queue fills; the back end pulls only
// while the result queue has room for every beat already in its pipeline.
`default_nettype none
`include "utf8_text_width_meter_core_macros.svh"
module utf8_text_width_meter_core #(
   parameter int TABLE_DEPTH = utwm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int MID_DEPTH   = utwm_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH   = utwm_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_table_index,
   input  wire logic [15:0] req_advance_value,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_last,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_char_done,
   output logic [7:0]       rsp_glyph_index,
   output logic             rsp_missing_glyph,
   output logic [31:0]      rsp_running_width,
   output logic             rsp_width_valid,
   output logic [31:0]      rsp_final_width,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   localparam int MW  = $bits(utwm_pkg::mid_item_type);
   localparam int OW  = $bits(utwm_pkg::out_item_type);
   localparam int OCW = $clog2(OUT_DEPTH+1);

   logic                   accept;
   utwm_pkg::mid_item_type front_item;
   logic [MW-1:0]          mid_rd;
   logic                   mid_empty, mid_pop;
   utwm_pkg::mid_item_type mid_item;

   logic                   out_push, out_full;
   utwm_pkg::out_item_type out_wr_item;
   logic [OW-1:0]          out_rd;
   utwm_pkg::out_item_type out_item;
   logic [OCW-1:0]         out_count;

   assign accept = push && !full;

   utwm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req_opcode),
      .table_index   (req_table_index),
      .advance_value (req_advance_value),
      .text_byte     (req_text_byte),
      .last          (req_last),
      .item          (front_item)
   );

   utwm_queue #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (mid_pop),
      .pop_data  (mid_rd),
      .empty     (mid_empty),
      .count     ()
   );

   assign mid_item = utwm_pkg::mid_item_type'(mid_rd);

   utwm_back #(.TABLE_DEPTH(TABLE_DEPTH), .OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .mid_empty (mid_empty),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_wr_item)
   );

   utwm_queue #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_rd),
      .empty     (empty),
      .count     (out_count)
   );

   assign out_item          = utwm_pkg::out_item_type'(out_rd);
   assign rsp_char_done     = out_item.char_done;
   assign rsp_glyph_index   = out_item.glyph_index;
   assign rsp_missing_glyph = out_item.missing_glyph;
   assign rsp_running_width = out_item.running_width;
   assign rsp_width_valid   = out_item.width_valid;
   assign rsp_final_width   = out_item.final_width;

   `UTWM_ASSERT(a_out_no_overflow, clock, reset, out_push |-> !out_full)
   `UTWM_ASSERT(a_mid_pop_nonempty, clock, reset, mid_pop |-> !mid_empty)
   `UTWM_ASSERT(a_glyph_range, clock, reset, (!empty && rsp_char_done) |-> (rsp_glyph_index <= 8'd160))
   `UTWM_ASSERT_RST(a_reset_empty, clock, reset |=> (empty && !full))

endmodule
`default_nettype wire
